[rtl/core/digraph_letter_sentence_histogram_defines.svh]
// assertion macros shared by the sentence histogram rtl
// no dependencies; included by the files that carry assertions
`ifndef DIGRAPH_LETTER_SENTENCE_HISTOGRAM_DEFINES_SVH
`define DIGRAPH_LETTER_SENTENCE_HISTOGRAM_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DLSH_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define DLSH_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/dlsh_pkg.sv]
// types, constants and lookup functions for the sentence histogram
// no dependencies; imported by dlsh_ctrl, dlsh_dp and the top level
package dlsh_pkg;

    localparam int NUM_LETTERS_DEF = 36;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam logic [15:0] CH_NUL   = 16'h0000;
    localparam logic [15:0] CH_LF    = 16'h000A;
    localparam logic [15:0] CH_FF    = 16'h000C;
    localparam logic [15:0] CH_CR    = 16'h000D;
    localparam logic [15:0] CH_SPACE = 16'h0020;
    localparam logic [15:0] CH_DOT   = 16'h002E;
    localparam logic [15:0] CH_QMARK = 16'h003F;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CLASS,
        ST_PEND_WR,
        ST_BUMP_WR,
        ST_EMIT_RD,
        ST_EMIT_LD
    } dlsh_state_t;

    typedef enum logic [2:0] {
        RS_PEND,
        RS_SINGLE,
        RS_LETTER,
        RS_EMIT,
        RS_EMIT_NEXT
    } dlsh_rd_sel_t;

    typedef struct packed {
        logic         load_item;
        logic         rd_en;
        dlsh_rd_sel_t rd_sel;
        logic         bump_wr;
        logic         grow;
        logic         clr_pending;
        logic         set_pending;
        logic         set_prev;
        logic         emit_load;
        logic         clr_len;
    } dlsh_cmd_t;

    typedef struct packed {
        logic func;
        logic pend_valid;
        logic pend_match;
        logic is_end;
        logic is_skip;
        logic is_null;
        logic is_letter;
        logic is_lead;
        logic len_zero;
        logic out_free;
        logic emit_last;
    } dlsh_status_t;

    typedef struct packed {
        logic       hit;
        logic       lead;
        logic [5:0] pos;
    } dlsh_letter_t;

    // alphabet position of a letter, either case; digraph leads carry the
    // position of the digraph
    function automatic dlsh_letter_t letter_lookup(input logic [15:0] c);
        dlsh_letter_t r;
        r = '0;
        r.hit = 1'b1;
        case (c)
            16'h0041, 16'h0061: r.pos = 6'd0;
            16'h0042, 16'h0062: r.pos = 6'd1;
            16'h0043, 16'h0063: r.pos = 6'd2;
            16'h00C7, 16'h00E7: r.pos = 6'd3;
            16'h0044, 16'h0064: begin r.pos = 6'd5;  r.lead = 1'b1; end
            16'h0045, 16'h0065: r.pos = 6'd6;
            16'h00CB, 16'h00EB: r.pos = 6'd7;
            16'h0046, 16'h0066: r.pos = 6'd8;
            16'h0047, 16'h0067: begin r.pos = 6'd10; r.lead = 1'b1; end
            16'h0048, 16'h0068: r.pos = 6'd11;
            16'h0049, 16'h0069: r.pos = 6'd12;
            16'h004A, 16'h006A: r.pos = 6'd13;
            16'h004B, 16'h006B: r.pos = 6'd14;
            16'h004C, 16'h006C: begin r.pos = 6'd16; r.lead = 1'b1; end
            16'h004D, 16'h006D: r.pos = 6'd17;
            16'h004E, 16'h006E: begin r.pos = 6'd19; r.lead = 1'b1; end
            16'h004F, 16'h006F: r.pos = 6'd20;
            16'h0050, 16'h0070: r.pos = 6'd21;
            16'h0051, 16'h0071: r.pos = 6'd22;
            16'h0052, 16'h0072: begin r.pos = 6'd24; r.lead = 1'b1; end
            16'h0053, 16'h0073: begin r.pos = 6'd26; r.lead = 1'b1; end
            16'h0054, 16'h0074: begin r.pos = 6'd28; r.lead = 1'b1; end
            16'h0055, 16'h0075: r.pos = 6'd29;
            16'h0056, 16'h0076: r.pos = 6'd30;
            16'h0058, 16'h0078: begin r.pos = 6'd32; r.lead = 1'b1; end
            16'h0059, 16'h0079: r.pos = 6'd33;
            16'h005A, 16'h007A: begin r.pos = 6'd35; r.lead = 1'b1; end
            default:            r.hit = 1'b0;
        endcase
        return r;
    endfunction

    // true when c completes the digraph at position pos
    function automatic logic digraph_second(input logic [5:0] pos, input logic [15:0] c);
        logic r;
        r = 1'b0;
        case (pos)
            6'd5, 6'd26, 6'd28, 6'd32, 6'd35: r = (c == 16'h0048) || (c == 16'h0068);
            6'd10, 6'd19:                      r = (c == 16'h004A) || (c == 16'h006A);
            6'd16:                             r = (c == 16'h004C) || (c == 16'h006C);
            6'd24:                             r = (c == 16'h0052) || (c == 16'h0072);
            default:                           r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/digraph_letter_sentence_histogram.sv]
// top level of the per-sentence letter histogram
// depends on dlsh_pkg, dlsh_ctrl and dlsh_dp

// Takes one 16-bit character (or an end-of-text flush) per request and counts
// the Albanian letters of the current sentence, digraphs included, in a
// NUM_LETTERS-entry count memory with one read and one write port. A plain
// character, skipped character or digraph lead goes back to idle after decode;
// a counted letter adds a write state and a lone lead adds a write and a second
// decode, since each count update is a read then a write of the count memory.
// A closing mark or a flush with text pending then emits NUM_LETTERS results,
// one per cycle while m_ready is high, out of the result register. After reset
// the counts read as zero at once, with no clearing pass.
module digraph_letter_sentence_histogram #(
    parameter int NUM_LETTERS = dlsh_pkg::NUM_LETTERS_DEF,
    parameter int COUNT_WIDTH = dlsh_pkg::COUNT_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [15:0] s_char_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_letter_index,
    output logic [15:0] m_letter_count,
    output logic [15:0] m_sentence_length,
    output logic        m_last
);
    import dlsh_pkg::*;

    dlsh_cmd_t    cmd;
    dlsh_status_t status;

    dlsh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dlsh_dp #(
        .NUM_LETTERS (NUM_LETTERS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_func            (s_func),
        .s_char_code       (s_char_code),
        .cmd               (cmd),
        .status            (status),
        .m_ready           (m_ready),
        .m_valid           (m_valid),
        .m_letter_index    (m_letter_index),
        .m_letter_count    (m_letter_count),
        .m_sentence_length (m_sentence_length),
        .m_last            (m_last)
    );

endmodule

[rtl/core/dlsh_dp.sv]
// datapath: item register, sentence state, count memory and result register
// depends on dlsh_pkg and digraph_letter_sentence_histogram_defines.svh
`include "digraph_letter_sentence_histogram_defines.svh"

module dlsh_dp #(
    parameter int NUM_LETTERS = dlsh_pkg::NUM_LETTERS_DEF,
    parameter int COUNT_WIDTH = dlsh_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_func,
    input  logic [15:0]            s_char_code,
    input  dlsh_pkg::dlsh_cmd_t    cmd,
    output dlsh_pkg::dlsh_status_t status,
    input  logic                   m_ready,
    output logic                   m_valid,
    output logic [5:0]             m_letter_index,
    output logic [15:0]            m_letter_count,
    output logic [15:0]            m_sentence_length,
    output logic                   m_last
);
    import dlsh_pkg::*;

    localparam int AW = $clog2(NUM_LETTERS);
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_LETTERS - 1);
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    logic                   func_reg;
    logic [15:0]            char_reg;
    logic [15:0]            len_reg;
    logic [15:0]            prev_reg;
    logic                   pend_valid_reg;
    logic [5:0]             pend_idx_reg;
    logic [AW-1:0]          emit_idx_reg;
    logic [COUNT_WIDTH-1:0] count_mem [NUM_LETTERS];
    logic [NUM_LETTERS-1:0] valid_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic [AW-1:0]          rd_addr_reg;
    logic                   m_valid_reg;
    logic [5:0]             m_index_reg;
    logic [15:0]            m_count_reg;
    logic [15:0]            m_len_reg;
    logic                   m_last_reg;

    dlsh_letter_t           letter;
    logic [AW-1:0]          rd_addr;
    logic [COUNT_WIDTH-1:0] bump_val;
    logic                   emit_last;

    assign letter    = letter_lookup(char_reg);
    assign emit_last = (emit_idx_reg == LAST_IDX);
    assign bump_val  = (rd_data_reg == CMAX) ? rd_data_reg
                                             : rd_data_reg + COUNT_WIDTH'(1);

    always_comb begin
        status            = '0;
        status.func       = func_reg;
        status.pend_valid = pend_valid_reg;
        status.pend_match = pend_valid_reg && !func_reg
                            && digraph_second(pend_idx_reg, char_reg);
        status.is_end     = ((char_reg == CH_DOT) && (prev_reg != CH_DOT))
                            || ((char_reg == CH_QMARK) && (prev_reg != CH_QMARK));
        status.is_skip    = (char_reg == CH_LF) || (char_reg == CH_FF)
                            || (char_reg == CH_CR)
                            || ((char_reg == CH_SPACE) && (len_reg == 16'd0))
                            || ((prev_reg == CH_DOT) && (char_reg == CH_DOT));
        status.is_null    = (char_reg == CH_NUL);
        status.is_letter  = letter.hit;
        status.is_lead    = letter.lead;
        status.len_zero   = (len_reg == 16'd0);
        status.out_free   = !m_valid_reg || m_ready;
        status.emit_last  = emit_last;
    end

    always_comb begin
        case (cmd.rd_sel)
            RS_PEND:      rd_addr = AW'(pend_idx_reg);
            RS_SINGLE:    rd_addr = AW'(pend_idx_reg - 6'd1);
            RS_LETTER:    rd_addr = AW'(letter.pos);
            RS_EMIT:      rd_addr = emit_idx_reg;
            RS_EMIT_NEXT: rd_addr = emit_idx_reg + AW'(1);
            default:      rd_addr = '0;
        endcase
    end

    // item register
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            func_reg <= s_func;
            char_reg <= s_char_code;
        end
    end

    // count memory, read data registered; an entry without its valid bit reads zero
    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_data_reg <= valid_reg[rd_addr] ? count_mem[rd_addr] : '0;
            rd_addr_reg <= rd_addr;
        end
        if (cmd.bump_wr) begin
            count_mem[rd_addr_reg] <= bump_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (cmd.bump_wr) begin
                valid_reg[rd_addr_reg] <= 1'b1;
            end
            // emission clears the entry it has just read
            if (cmd.emit_load) begin
                valid_reg[emit_idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg        <= '0;
            prev_reg       <= '0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
            emit_idx_reg   <= '0;
        end else begin
            if (cmd.clr_len) begin
                len_reg <= '0;
            end else if (cmd.grow && (len_reg != 16'hFFFF)) begin
                len_reg <= len_reg + 16'd1;
            end
            if (cmd.set_prev) begin
                prev_reg <= char_reg;
            end
            if (cmd.set_pending) begin
                pend_valid_reg <= 1'b1;
                pend_idx_reg   <= letter.pos;
            end else if (cmd.clr_pending) begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.emit_load) begin
                emit_idx_reg <= emit_last ? '0 : emit_idx_reg + AW'(1);
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            m_index_reg <= 6'(emit_idx_reg);
            m_count_reg <= 16'(rd_data_reg);
            m_len_reg   <= len_reg;
            m_last_reg  <= emit_last;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_letter_index    = m_index_reg;
    assign m_letter_count    = m_count_reg;
    assign m_sentence_length = m_len_reg;
    assign m_last            = m_last_reg;

    `DLSH_ASSERT_NOW(a_load_needs_room, aclk, aresetn, cmd.emit_load, status.out_free, "result loaded over a waiting result")
    `DLSH_ASSERT_NEXT(a_run_clears_len, aclk, aresetn, cmd.emit_load && emit_last, len_reg == 16'd0, "length not cleared after run")
    `DLSH_ASSERT_NOW(a_bump_after_read, aclk, aresetn, cmd.bump_wr, $past(cmd.rd_en), "count written without a read before it")

endmodule

[rtl/core/dlsh_ctrl.sv]
// controller state machine: sequences decode, count updates and emission
// depends on dlsh_pkg and digraph_letter_sentence_histogram_defines.svh
`include "digraph_letter_sentence_histogram_defines.svh"

module dlsh_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  dlsh_pkg::dlsh_status_t status,
    output dlsh_pkg::dlsh_cmd_t    cmd
);
    import dlsh_pkg::*;

    dlsh_state_t state_reg;
    dlsh_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        s_ready    = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EVAL;
                end
            end
            ST_EVAL, ST_CLASS: begin
                if ((state_reg == ST_EVAL) && status.pend_valid) begin
                    cmd.clr_pending = 1'b1;
                    cmd.rd_en       = 1'b1;
                    if (status.pend_match) begin
                        // digraph completed, character consumed
                        cmd.rd_sel = RS_PEND;
                        cmd.grow   = 1'b1;
                        state_next = ST_BUMP_WR;
                    end else begin
                        // lead stands alone, then handle the character
                        cmd.rd_sel = RS_SINGLE;
                        state_next = ST_PEND_WR;
                    end
                end else if (status.func) begin
                    state_next = status.len_zero ? ST_IDLE : ST_EMIT_RD;
                end else if (status.is_end) begin
                    cmd.grow     = 1'b1;
                    cmd.set_prev = 1'b1;
                    state_next   = ST_EMIT_RD;
                end else if (status.is_skip) begin
                    cmd.set_prev = 1'b1;
                    state_next   = ST_IDLE;
                end else if (status.is_null) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.grow   = 1'b1;
                    state_next = ST_IDLE;
                    if (status.is_letter) begin
                        cmd.set_prev = 1'b1;
                        if (status.is_lead) begin
                            cmd.set_pending = 1'b1;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RS_LETTER;
                            state_next = ST_BUMP_WR;
                        end
                    end
                end
            end
            ST_PEND_WR: begin
                cmd.bump_wr = 1'b1;
                state_next  = ST_CLASS;
            end
            ST_BUMP_WR: begin
                cmd.bump_wr = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_EMIT_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RS_EMIT;
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (status.out_free) begin
                    cmd.emit_load = 1'b1;
                    if (status.emit_last) begin
                        cmd.clr_len = 1'b1;
                        state_next  = ST_IDLE;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RS_EMIT_NEXT;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `DLSH_ASSERT_NEXT(a_accept_to_eval, aclk, aresetn, s_valid && s_ready, state_reg == ST_EVAL, "accepted request did not go to evaluation")
    `DLSH_ASSERT_NEXT(a_run_ends_idle, aclk, aresetn, (state_reg == ST_EMIT_LD) && status.out_free && status.emit_last, state_reg == ST_IDLE, "run did not end in idle")
    `DLSH_ASSERT_NEXT(a_pend_wr_to_class, aclk, aresetn, state_reg == ST_PEND_WR, state_reg == ST_CLASS, "single lead write did not resume decode")

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// self-checking bench for digraph_letter_sentence_histogram: directed and random text,
// random idling on both sides and one long result hold-off
// depends on dlsh_pkg and the digraph_letter_sentence_histogram rtl
module testbench;

    import dlsh_pkg::*;

    localparam int N_BINS    = NUM_LETTERS_DEF;
    localparam bit FN_CHAR   = 1'b0;
    localparam bit FN_FLUSH  = 1'b1;
    localparam int HOLD_LEN  = 600;
    localparam int HOLD_AT   = 200;
    localparam int RAND_REQS = 240;

    typedef struct {
        bit          func;
        logic [15:0] code;
    } text_req_t;

    typedef struct {
        logic [5:0]  index;
        logic [15:0] count;
        logic [15:0] length;
        logic        last;
    } histo_bin_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_func = 1'b0;
    logic [15:0] s_char_code = 16'h0000;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [5:0]  m_letter_index;
    logic [15:0] m_letter_count;
    logic [15:0] m_sentence_length;
    logic        m_last;

    text_req_t  text_reqs[$];
    histo_bin_t expected_bins[$];
    text_req_t  next_req;
    histo_bin_t got_bin;
    int         errors = 0;
    int         src_gap = 0;
    int         sink_gap = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;

    // predictor state
    logic [15:0] letter_tally[N_BINS];
    logic [15:0] sentence_len = 16'h0000;
    logic [15:0] prev_code = 16'h0000;
    bit          lead_open = 1'b0;
    logic [5:0]  lead_slot = 6'd0;

    digraph_letter_sentence_histogram dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_char_code       (s_char_code),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_letter_index    (m_letter_index),
        .m_letter_count    (m_letter_count),
        .m_sentence_length (m_sentence_length),
        .m_last            (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [15:0] fold_case(logic [15:0] c);
        if ((c >= 16'h0041 && c <= 16'h005A) || c == 16'h00C7 || c == 16'h00CB) begin
            return c | 16'h0020;
        end
        return c;
    endfunction

    // lower-case second letter of the digraph at a slot, zero for plain letters
    function automatic logic [15:0] digraph_tail(logic [5:0] slot);
        case (slot)
            6'd5, 6'd26, 6'd28, 6'd32, 6'd35: return "h";
            6'd10, 6'd19:                     return "j";
            6'd16:                            return "l";
            6'd24:                            return "r";
            default:                          return 16'h0000;
        endcase
    endfunction

    // alphabet slot of a folded character, digraph leads give the digraph slot
    function automatic int letter_slot(logic [15:0] lc);
        case (lc)
            "a": return 0;
            "b": return 1;
            "c": return 2;
            16'h00E7: return 3;
            "d": return 5;
            "e": return 6;
            16'h00EB: return 7;
            "f": return 8;
            "g": return 10;
            "h": return 11;
            "i": return 12;
            "j": return 13;
            "k": return 14;
            "l": return 16;
            "m": return 17;
            "n": return 19;
            "o": return 20;
            "p": return 21;
            "q": return 22;
            "r": return 24;
            "s": return 26;
            "t": return 28;
            "u": return 29;
            "v": return 30;
            "x": return 32;
            "y": return 33;
            "z": return 35;
            default: return -1;
        endcase
    endfunction

    task automatic bump_tally(logic [5:0] slot);
        if (letter_tally[slot] != 16'hFFFF) letter_tally[slot]++;
    endtask

    task automatic grow_sentence();
        if (sentence_len != 16'hFFFF) sentence_len++;
    endtask

    task automatic close_sentence();
        histo_bin_t b;
        for (int k = 0; k < N_BINS; k++) begin
            b.index  = 6'(k);
            b.count  = letter_tally[k];
            b.length = sentence_len;
            b.last   = (k == N_BINS - 1);
            expected_bins = {expected_bins, b};
            letter_tally[k] = 16'h0000;
        end
        sentence_len = 16'h0000;
    endtask

    task automatic tally_char(bit func, logic [15:0] c);
        logic [15:0] lc;
        int          slot;
        lc = fold_case(c);
        if (lead_open) begin
            lead_open = 1'b0;
            if (func == FN_CHAR && lc == digraph_tail(lead_slot)) begin
                bump_tally(lead_slot);
                grow_sentence();
                return;
            end
            // lead stands alone: count the single letter just below the digraph
            bump_tally(lead_slot - 6'd1);
        end
        if (func == FN_FLUSH) begin
            if (sentence_len != 0) close_sentence();
            return;
        end
        if ((c == CH_DOT && prev_code != CH_DOT) || (c == CH_QMARK && prev_code != CH_QMARK)) begin
            grow_sentence();
            prev_code = c;
            close_sentence();
            return;
        end
        if (c == CH_LF || c == CH_FF || c == CH_CR || (c == CH_SPACE && sentence_len == 0) ||
                (c == CH_DOT && prev_code == CH_DOT)) begin
            prev_code = c;
            return;
        end
        if (c == CH_NUL) return;
        grow_sentence();
        slot = letter_slot(lc);
        if (slot >= 0) begin
            if (digraph_tail(6'(slot)) != 16'h0000) begin
                lead_open = 1'b1;
                lead_slot = 6'(slot);
            end else begin
                bump_tally(6'(slot));
            end
            prev_code = c;
        end
    endtask

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic bit idling_allowed(int left);
        return left >= 40 && (left / 50) % 3 != 1;
    endfunction

    task automatic push_req(bit func, logic [15:0] code);
        text_req_t r;
        r.func = func;
        r.code = code;
        text_reqs = {text_reqs, r};
    endtask

    function automatic logic [15:0] rand_case(logic [15:0] c);
        if (((c >= "a" && c <= "z") || c == 16'h00E7 || c == 16'h00EB) &&
                $urandom_range(0, 1) == 1) begin
            return c ^ 16'h0020;
        end
        return c;
    endfunction

    function automatic logic [15:0] rand_letter();
        int r;
        r = $urandom_range(0, 27);
        if (r < 26) return rand_case(16'h0061 + 16'(r));
        return rand_case(r == 26 ? 16'h00E7 : 16'h00EB);
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) tally_char(s_func, s_char_code);
            if (src_gap != 0) begin
                src_gap <= src_gap - 1;
                s_valid <= 1'b0;
            end else if (text_reqs.size() != 0 && idling_allowed(text_reqs.size()) &&
                    $urandom_range(0, 7) == 0) begin
                src_gap <= $urandom_range(0, 13);
                s_valid <= 1'b0;
            end else if (text_reqs.size() != 0) begin
                next_req = text_reqs.pop_front();
                s_valid <= 1'b1;
                s_func <= next_req.func;
                s_char_code <= next_req.code;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // long result hold-off while the sender keeps offering requests
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && text_reqs.size() == HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (hold_left != 0) begin
                m_ready <= 1'b0;
            end else if (sink_gap != 0) begin
                sink_gap <= sink_gap - 1;
                m_ready <= 1'b0;
            end else if (idling_allowed(text_reqs.size()) && $urandom_range(0, 7) == 0) begin
                sink_gap <= $urandom_range(0, 13);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
            if (m_valid && m_ready) begin
                if (expected_bins.size() == 0) begin
                    report_mismatch($sformatf("unexpected result index %0d count %0d",
                        m_letter_index, m_letter_count));
                end else begin
                    got_bin = expected_bins.pop_front();
                    if (m_letter_index !== got_bin.index)
                        report_mismatch($sformatf("letter_index got %0d want %0d",
                            m_letter_index, got_bin.index));
                    if (m_letter_count !== got_bin.count)
                        report_mismatch($sformatf("letter_count[%0d] got %0d want %0d",
                            got_bin.index, m_letter_count, got_bin.count));
                    if (m_sentence_length !== got_bin.length)
                        report_mismatch($sformatf("sentence_length[%0d] got %0d want %0d",
                            got_bin.index, m_sentence_length, got_bin.length));
                    if (m_last !== got_bin.last)
                        report_mismatch($sformatf("last[%0d] got %0b want %0b",
                            got_bin.index, m_last, got_bin.last));
                end
            end
        end
    end

    initial begin
        string pairs;
        int    rand_base;
        int    words;
        int    p;
        pairs = "dhgjllnjrrshthxhzh";
        for (int k = 0; k < N_BINS; k++) letter_tally[k] = 16'h0000;

        // directed text
        push_req(FN_FLUSH, 16'h0000);           // flush with nothing pending
        push_req(FN_CHAR, CH_NUL);
        push_req(FN_CHAR, CH_SPACE);            // leading space dropped
        push_req(FN_CHAR, "A");
        push_req(FN_CHAR, 16'h00C7);
        push_req(FN_CHAR, 16'h00EB);
        push_req(FN_CHAR, "D");
        push_req(FN_CHAR, "h");
        push_req(FN_CHAR, "g");
        push_req(FN_CHAR, "X");                 // lone g, then x waits
        push_req(FN_CHAR, "H");
        push_req(FN_CHAR, 16'hFFFF);
        push_req(FN_CHAR, CH_LF);
        push_req(FN_CHAR, CH_FF);
        push_req(FN_CHAR, CH_CR);
        push_req(FN_CHAR, CH_QMARK);
        push_req(FN_CHAR, CH_QMARK);            // repeated mark stays in the text
        push_req(FN_CHAR, CH_DOT);
        push_req(FN_CHAR, CH_DOT);              // dot after dot skipped
        push_req(FN_CHAR, "z");
        push_req(FN_FLUSH, "h");                // flush never completes a digraph
        push_req(FN_CHAR, "N");
        push_req(FN_CHAR, "j");
        push_req(FN_CHAR, "s");
        push_req(FN_CHAR, CH_QMARK);

        // random sentences with some noise and broken sequences mixed in
        rand_base = text_reqs.size();
        while (text_reqs.size() - rand_base < RAND_REQS) begin
            words = $urandom_range(1, 10);
            for (int w = 0; w < words; w++) begin
                p = $urandom_range(0, 8) * 2;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: push_req(FN_CHAR, rand_letter());
                    4, 5: begin
                        push_req(FN_CHAR, rand_case(16'(pairs[p])));
                        push_req(FN_CHAR, rand_case(16'(pairs[p + 1])));
                    end
                    6: begin
                        push_req(FN_CHAR, rand_case(16'(pairs[p])));
                        push_req(FN_CHAR, rand_letter());
                    end
                    7: push_req(FN_CHAR, CH_SPACE);
                    8: push_req(FN_CHAR, 16'($urandom_range(0, 65535)));
                    default: begin
                        case ($urandom_range(0, 4))
                            0:       push_req(FN_CHAR, CH_LF);
                            1:       push_req(FN_CHAR, CH_FF);
                            2:       push_req(FN_CHAR, CH_CR);
                            3:       push_req(FN_CHAR, CH_NUL);
                            default: push_req(FN_CHAR, CH_SPACE);
                        endcase
                    end
                endcase
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: push_req(FN_CHAR, CH_DOT);
                4, 5, 6:    push_req(FN_CHAR, CH_QMARK);
                7: begin
                    push_req(FN_CHAR, CH_QMARK);
                    push_req(FN_CHAR, CH_QMARK);
                    push_req(FN_CHAR, CH_DOT);
                end
                8: begin
                    push_req(FN_CHAR, CH_DOT);
                    push_req(FN_CHAR, CH_DOT);
                end
                default: push_req(FN_FLUSH, 16'($urandom_range(0, 65535)));
            endcase
        end
        push_req(FN_FLUSH, 16'h0000);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (text_reqs.size() != 0 || s_valid) @(posedge aclk);
        while (expected_bins.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/dlsh_pkg.sv
rtl/core/dlsh_dp.sv
rtl/core/dlsh_ctrl.sv
rtl/core/digraph_letter_sentence_histogram.sv
tb/sv/testbench.sv
